[design/swr_pkg.sv]
package swr_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;
  localparam int FILL_W = 7;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY     = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic                     valid;
    logic [STS_W-1:0]         status;
    logic signed [DATA_W-1:0] data;
    logic [FILL_W-1:0]        fill;
  } result_t;

endpackage

[design/stack_with_remove_by_value.sv]
// Bounded LIFO stack of signed 32-bit words held in one single-port-read RAM. One request is
// worked at a time; every request returns status, data and the fill count after it. Push and
// any refused request finish in the cycle they are accepted; pop and peek pass through S_READ
// for one RAM read. Remove-by-value walks the RAM from the top, one entry per cycle through
// the single read port, then moves each entry above the match down one place, one per cycle.
// A two-deep output buffer lets the next request be accepted while a result still waits.
module stack_with_remove_by_value
  import swr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STS_W-1:0]         out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic [FILL_W-1:0]        out_fill
);

  mem_req_t          mem;
  result_t           res;
  logic              idle;
  logic              accept;
  logic [DATA_W-1:0] rd_data;

  logic                     out_valid_r;
  logic                     skid_valid_r;
  logic [STS_W-1:0]         out_status_r, skid_status_r;
  logic signed [DATA_W-1:0] out_data_r, skid_data_r;
  logic [FILL_W-1:0]        out_fill_r, skid_fill_r;
  logic                     out_take;

  assign in_ready = idle && !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;

  swr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .op      (in_op),
    .value   (in_value),
    .rd_data (rd_data),
    .idle    (idle),
    .mem     (mem),
    .res     (res)
  );

  swr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (res.valid && (!out_valid_r || out_take)) begin
        out_valid_r <= 1'b1;
      end else if (res.valid) begin
        skid_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
    priority if (res.valid && (!out_valid_r || out_take)) begin
      out_status_r <= res.status;
      out_data_r   <= res.data;
      out_fill_r   <= res.fill;
    end else if (res.valid) begin
      skid_status_r <= res.status;
      skid_data_r   <= res.data;
      skid_fill_r   <= res.fill;
    end else if (out_take) begin
      out_status_r <= skid_status_r;
      out_data_r   <= skid_data_r;
      out_fill_r   <= skid_fill_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_fill   = out_fill_r;

`ifndef NO_ASSERTIONS
  a_no_result_into_full_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !skid_valid_r)
    else $error("result produced while output buffer is full");

  a_push_finishes_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_PUSH) |-> res.valid)
    else $error("push did not finish in its accept cycle");

  a_skid_only_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");
`endif

endmodule

[design/swr_ram.sv]
module swr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/swr_ctrl.sv]
module swr_ctrl
  import swr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [OP_W-1:0]          op,
  input  logic signed [DATA_W-1:0] value,
  input  logic [DATA_W-1:0]        rd_data,
  output logic                     idle,
  output mem_req_t                 mem,
  output result_t                  res
);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     pop_r, pop_nxt;
  logic [AW-1:0]            top_idx;
  logic                     full;
  logic                     empty;
  logic                     hit;

  assign top_idx = AW'(cnt_r - CW'(1));
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign hit     = (rd_data == key_r);
  assign idle    = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    pop_r <= pop_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    pop_nxt    = pop_r;
    mem.we     = 1'b0;
    mem.waddr  = pos_r - AW'(1);
    mem.wdata  = rd_data;
    mem.raddr  = top_idx;
    res.valid  = 1'b0;
    res.status = STS_DONE;
    res.data   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_PUSH: begin
              res.valid = 1'b1;
              if (full) begin
                res.status = STS_FULL;
              end else begin
                mem.we    = 1'b1;
                mem.waddr = AW'(cnt_r);
                mem.wdata = value;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.status = STS_EMPTY;
              end else begin
                pop_nxt   = (op == OP_POP);
                state_nxt = S_READ;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                res.valid  = 1'b1;
                res.status = STS_NOT_FOUND;
              end else begin
                pos_nxt   = top_idx;
                key_nxt   = value;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              res.valid = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        res.valid = 1'b1;
        res.data  = rd_data;
        if (pop_r) begin
          cnt_nxt = cnt_r - CW'(1);
        end
        state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        priority if (hit && pos_r == top_idx) begin
          cnt_nxt   = cnt_r - CW'(1);
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end else if (hit) begin
          mem.raddr = pos_r + AW'(1);
          pos_nxt   = pos_r + AW'(1);
          state_nxt = S_SHIFT;
        end else if (pos_r == '0) begin
          res.valid  = 1'b1;
          res.status = STS_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          mem.raddr = pos_r - AW'(1);
          pos_nxt   = pos_r - AW'(1);
        end
      end
      S_SHIFT: begin
        mem.we = 1'b1;
        if (pos_r == top_idx) begin
          cnt_nxt   = cnt_r - CW'(1);
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem.raddr = pos_r + AW'(1);
          pos_nxt   = pos_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.fill = FILL_W'(cnt_nxt);
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
module testbench
  import swr_pkg::*;
();

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } stack_req_t;

  typedef struct {
    logic [STS_W-1:0]         status;
    logic signed [DATA_W-1:0] data;
    logic [FILL_W-1:0]        fill;
  } stack_reply_t;

  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 16;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_op     = OP_PUSH;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STS_W-1:0]         out_status;
  logic signed [DATA_W-1:0] out_data;
  logic [FILL_W-1:0]        out_fill;

  stack_with_remove_by_value uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_fill   (out_fill)
  );

  always #5 clk = ~clk;

  stack_req_t        pending_reqs[$];
  stack_reply_t      expected_replies[$];
  stack_req_t        next_req;
  stack_reply_t      head_reply;
  logic [DATA_W-1:0] shadow_entries[DEPTH];
  int                shadow_fill = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  logic              req_taken = 1'b0;
  int                reqs_queued = 0;
  int                reqs_sent = 0;
  int                replies_checked = 0;
  int                mismatch_count = 0;
  int                full_refusals = 0;
  int                removes_hit = 0;
  int                removes_missed = 0;

  function automatic stack_reply_t stack_apply(input logic [OP_W-1:0] op,
                                               input logic [DATA_W-1:0] value);
    stack_reply_t r;
    int pos;
    r.status = STS_DONE;
    r.data   = '0;
    case (op)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STS_FULL;
          full_refusals++;
        end else begin
          shadow_entries[shadow_fill] = value;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          shadow_fill--;
          r.data = shadow_entries[shadow_fill];
        end
      end
      OP_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.data = shadow_entries[shadow_fill - 1];
        end
      end
      default: begin
        pos = shadow_fill - 1;
        while (pos >= 0 && shadow_entries[pos] != value) pos--;
        if (pos < 0) begin
          r.status = STS_NOT_FOUND;
          removes_missed++;
        end else begin
          for (int k = pos; k + 1 < shadow_fill; k++) shadow_entries[k] = shadow_entries[k + 1];
          shadow_fill--;
          removes_hit++;
        end
      end
    endcase
    r.fill = FILL_W'(shadow_fill);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 99) < 60) begin
      case ($urandom_range(0, 7))
        0: v = 32'h0000_0000;
        1: v = 32'hFFFF_FFFF;
        2: v = 32'h0000_0001;
        3: v = 32'h8000_0000;
        4: v = 32'h7FFF_FFFF;
        5: v = 32'h5555_5555;
        6: v = 32'hAAAA_AAAA;
        default: v = 32'h0000_0007;
      endcase
    end
    return v;
  endfunction

  task automatic add_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    stack_req_t q;
    q.op    = op;
    q.value = value;
    pending_reqs.push_back(q);
    reqs_queued++;
  endtask

  task automatic add_burst();
    int kind;
    int r;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat (32) begin
        r = $urandom_range(0, 99);
        if (r < 40) add_req(OP_PUSH, pick_value());
        else if (r < 60) add_req(OP_POP, $urandom);
        else if (r < 70) add_req(OP_PEEK, $urandom);
        else add_req(OP_REMOVE, pick_value());
      end
    end else if (kind < 9) begin
      repeat (DEPTH + 2) add_req(OP_PUSH, pick_value());
      repeat (24) add_req(OP_REMOVE, pick_value());
    end else begin
      repeat (DEPTH + 2) begin
        if ($urandom_range(0, 3) == 0) add_req(OP_REMOVE, pick_value());
        else add_req(OP_POP, $urandom);
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op    <= next_req.op;
          in_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_replies.push_back(stack_apply(in_op, in_value));
        reqs_sent++;
      end
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result: status %0d data %0d fill %0d",
                   $time, out_status, out_data, out_fill);
          mismatch_count++;
        end else begin
          head_reply = expected_replies.pop_front();
          replies_checked++;
          if (out_status !== head_reply.status || out_data !== head_reply.data ||
              out_fill !== head_reply.fill) begin
            $display("%0t: expected sts %0d data %0d fill %0d, got sts %0d data %0d fill %0d",
                     $time, head_reply.status, head_reply.data, head_reply.fill,
                     out_status, out_data, out_fill);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    add_req(OP_POP,    32'h0000_0000);
    add_req(OP_PEEK,   32'hFFFF_FFFF);
    add_req(OP_REMOVE, 32'h0000_0000);
    add_req(OP_PUSH,   32'h8000_0000);
    add_req(OP_REMOVE, 32'h7FFF_FFFF);
    add_req(OP_REMOVE, 32'h8000_0000);
    add_req(OP_PUSH,   32'h7FFF_FFFF);
    add_req(OP_PUSH,   32'h0000_0000);
    add_req(OP_PUSH,   32'hFFFF_FFFF);
    add_req(OP_PUSH,   32'h0000_0000);
    add_req(OP_PUSH,   32'h0000_0005);
    add_req(OP_REMOVE, 32'h0000_0000);
    add_req(OP_PEEK,   32'h1234_5678);
    add_req(OP_POP,    32'hFFFF_FFFF);
    add_req(OP_POP,    32'h0000_0000);
    add_req(OP_POP,    32'hAAAA_AAAA);
    add_req(OP_REMOVE, 32'h7FFF_FFFF);
    add_req(OP_PUSH,   32'h1234_5678);
    add_req(OP_REMOVE, 32'h1234_5679);
    add_req(OP_REMOVE, 32'h1234_5678);
    add_req(OP_POP,    32'h5555_5555);
    add_req(OP_PEEK,   32'h0000_0000);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      while (reqs_queued < (p + 1) * RANDOM_ITEMS / PHASES) add_burst();
      while (pending_reqs.size() != 0) @(posedge clk);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (in_valid || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests and checked %0d results over four idle and stall mixes.",
             reqs_sent, replies_checked);
    $display("Removes found %0d, removes missed %0d, pushes refused on full %0d.",
             removes_hit, removes_missed, full_refusals);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("[stack_with_remove_by_value] OK");
    end else begin
      $display("[stack_with_remove_by_value] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timed out with %0d results outstanding", expected_replies.size());
    $display("[stack_with_remove_by_value] ERROR");
    $finish;
  end

endmodule
